FILE: design/binary_cross_entropy_loss_defines.svh
// Assertion macros shared by the binary cross-entropy loss block.
// Depends on nothing; included by files that carry assertions.
`ifndef BINARY_CROSS_ENTROPY_LOSS_DEFINES_SVH
`define BINARY_CROSS_ENTROPY_LOSS_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset.
`define BCE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bce assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define BCE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bce assertion failed");

`endif

FILE: design/bce_pkg.sv
// Package for the binary cross-entropy loss block: fixed-point constants
// and the probability clamp. Depends on nothing.
`timescale 1ns / 1ps
package bce_pkg;
  localparam int PROB_BITS = 16;
  localparam int FIELD_W   = PROB_BITS + 1;
  localparam logic [FIELD_W-1:0] PROB_ONE = FIELD_W'(1) << PROB_BITS;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int SCALE_W = 24;
  localparam int LOSS_W  = 32;
  localparam int MAG_W   = 40;
  localparam int SQ_STEPS = 16;

  // Register indexes of the configuration port.
  localparam logic CFG_LOSS_SCALE = 1'b0;
  localparam logic CFG_USE_MASK   = 1'b1;

  // Clamp a probability field to one.
  function automatic logic [FIELD_W-1:0] sat_prob(input logic [FIELD_W-1:0] v);
    sat_prob = (v > PROB_ONE) ? PROB_ONE : v;
  endfunction
endpackage

FILE: design/bce_if.sv
// Valid/ready channel interfaces of the loss block (pairs in, losses out).
// Depends on bce_pkg for the field widths.
`timescale 1ns / 1ps
interface bce_in_if import bce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] predicted;
  logic [FIELD_W-1:0] target;
  logic [FIELD_W-1:0] mask_weight;
  logic               last_feature;
  modport source (output valid, predicted, target, mask_weight, last_feature,
                  input ready);
  modport sink (input valid, predicted, target, mask_weight, last_feature,
                output ready);
endinterface

interface bce_out_if import bce_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [LOSS_W-1:0] loss;
  logic                     saturated;
  modport source (output valid, loss, saturated, input ready);
  modport sink (input valid, loss, saturated, output ready);
endinterface

FILE: design/bce_mul.sv
// Shared 32x32 unsigned multiplier used by the squaring, ln2, weighting and scaling steps.
// Depends on nothing; the caller registers the product.
`timescale 1ns / 1ps
module bce_mul (
  input  logic [31:0] mul_a,
  input  logic [31:0] mul_b,
  output logic [63:0] mul_p
);
  // Full-width product.
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};
endmodule

FILE: design/binary_cross_entropy_loss.sv
// Each log term runs setup, 16 squaring steps, ln2 scaling and weighting; a pair has
// one or two terms, all on one multiplier. A last pair then adds the scale and output
// steps, plus the low and high mask-weighting steps with the mask enabled.
// The output register lets the next pair start while a loss waits to be taken.
// Reset is synchronous, active low: sum cleared, loss_scale 1.0, mask off.
`timescale 1ns / 1ps
`include "binary_cross_entropy_loss_defines.svh"
module binary_cross_entropy_loss import bce_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bce_in_if.sink             in_ch,
  bce_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [SCALE_W-1:0] cfg_wdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_SQ, S_LN, S_TERM, S_SCALE, S_MLO, S_MHI, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [FIELD_W-1:0] p_r, p_nxt, t_r, t_nxt, mw_r, mw_nxt;
  logic               last_r, last_nxt;
  logic               phase_r, phase_nxt;
  logic [30:0]        m_r, m_nxt;
  logic [4:0]         ex_r, ex_nxt;
  logic [15:0]        frac_r, frac_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [19:0]        nlog_r, nlog_nxt;
  logic [LOSS_W-1:0]  acc_r, acc_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [48:0]        lo_r, lo_nxt;
  logic [SCALE_W-1:0] scale_r;
  logic               use_mask_r;
  logic               out_valid_r, out_valid_nxt;
  logic [LOSS_W-1:0]  loss_r, loss_nxt;
  logic               sat_r, sat_nxt;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;

  logic [FIELD_W-1:0] x_w, b_w, w_w;
  logic [4:0]         e_w;
  logic [46:0]        x_sh;
  logic [31:0]        sq_w;
  logic [20:0]        nl2_w;
  logic [63:0]        rnd_w;
  logic [20:0]        term_w;
  logic [32:0]        sum_w;
  logic [SCALE_W-1:0] smag_w;
  logic               neg_w;

  bce_mul u_mul (.mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.loss      = loss_r;
  assign out_ch.saturated = sat_r;

  // Log argument, its leading-one position, term weight, log2 value and scale magnitude.
  always_comb begin
    b_w = PROB_ONE - p_r;
    if (phase_r) begin
      x_w = (b_w == '0) ? FIELD_W'(1) : b_w;
    end else begin
      x_w = (p_r == '0) ? FIELD_W'(1) : p_r;
    end
    e_w = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (x_w[i]) e_w = 5'(i);
    end
    x_sh  = {30'b0, x_w} << (5'd30 - e_w);
    w_w   = phase_r ? (PROB_ONE - t_r) : t_r;
    nl2_w = {ex_r, 16'b0} - {5'b0, frac_r};
    neg_w = scale_r[SCALE_W-1];
    smag_w = neg_w ? (SCALE_W'(0) - scale_r) : scale_r;
  end

  // Sequencer: drives the shared multiplier and computes next state.
  always_comb begin
    state_nxt = state_r;
    p_nxt = p_r; t_nxt = t_r; mw_nxt = mw_r; last_nxt = last_r;
    phase_nxt = phase_r; m_nxt = m_r; ex_nxt = ex_r; frac_nxt = frac_r;
    cnt_nxt = cnt_r; nlog_nxt = nlog_r; acc_nxt = acc_r; mag_nxt = mag_r;
    lo_nxt = lo_r; out_valid_nxt = out_valid_r; loss_nxt = loss_r;
    sat_nxt = sat_r;
    mul_a = '0; mul_b = '0;
    sq_w = mul_p[61:30];
    rnd_w = '0;
    term_w = '0;
    sum_w = '0;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          p_nxt = sat_prob(in_ch.predicted);
          t_nxt = sat_prob(in_ch.target);
          mw_nxt = sat_prob(in_ch.mask_weight);
          last_nxt = in_ch.last_feature;
          phase_nxt = (sat_prob(in_ch.target) == '0);
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        m_nxt = x_sh[30:0];
        ex_nxt = 5'(PROB_BITS) - e_w;
        frac_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        // One fraction bit of log2 per squaring.
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
        m_nxt = sq_w[31] ? sq_w[31:1] : sq_w[30:0];
        frac_nxt = {frac_r[14:0], sq_w[31]};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(SQ_STEPS - 1)) state_nxt = S_LN;
      end
      S_LN: begin
        mul_a = {11'b0, nl2_w};
        mul_b = LN2_Q32;
        rnd_w = mul_p + 64'h8000_0000;
        nlog_nxt = rnd_w[51:32];
        state_nxt = S_TERM;
      end
      S_TERM: begin
        mul_a = {15'b0, w_w};
        mul_b = {12'b0, nlog_r};
        rnd_w = mul_p + 64'd32768;
        term_w = rnd_w[36:16];
        sum_w = {1'b0, acc_r} + {12'b0, term_w};
        acc_nxt = sum_w[32] ? '1 : sum_w[31:0];
        if (!phase_r && t_r != PROB_ONE) begin
          phase_nxt = 1'b1;
          state_nxt = S_SETUP;
        end else if (last_r) begin
          state_nxt = S_SCALE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCALE: begin
        mul_a = acc_r;
        mul_b = {8'b0, smag_w};
        rnd_w = mul_p + 64'd32768;
        mag_nxt = rnd_w[55:16];
        state_nxt = use_mask_r ? S_MLO : S_OUT;
      end
      S_MLO: begin
        mul_a = mag_r[31:0];
        mul_b = {15'b0, mw_r};
        lo_nxt = mul_p[48:0];
        state_nxt = S_MHI;
      end
      S_MHI: begin
        mul_a = {24'b0, mag_r[39:32]};
        mul_b = {15'b0, mw_r};
        rnd_w = {mul_p[31:0], 32'b0} + {15'b0, lo_r} + 64'd32768;
        mag_nxt = rnd_w[55:16];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Saturate to the signed range and emit the word.
        if (!out_valid_r) begin
          if (neg_w) begin
            sat_nxt = (mag_r > 40'h80_0000_0000 >> 8);
            loss_nxt = sat_nxt ? 32'h8000_0000 : (32'd0 - mag_r[31:0]);
          end else begin
            sat_nxt = (mag_r > 40'h00_7FFF_FFFF);
            loss_nxt = sat_nxt ? 32'h7FFF_FFFF : mag_r[31:0];
          end
          out_valid_nxt = 1'b1;
          acc_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, datapath and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r <= '0;
      out_valid_r <= 1'b0;
      scale_r <= SCALE_W'(65536);
      use_mask_r <= 1'b0;
      phase_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOSS_SCALE: scale_r <= cfg_wdata;
          CFG_USE_MASK:   use_mask_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    p_r <= p_nxt; t_r <= t_nxt; mw_r <= mw_nxt; last_r <= last_nxt;
    m_r <= m_nxt; ex_r <= ex_nxt; frac_r <= frac_nxt; nlog_r <= nlog_nxt;
    mag_r <= mag_nxt; lo_r <= lo_nxt; loss_r <= loss_nxt; sat_r <= sat_nxt;
  end

  // Sequencer checks.
  `BCE_ASSERT_NEXT(a_accept_setup, clk, rst_n, in_ch.valid && in_ch.ready, state_r == S_SETUP)
  `BCE_ASSERT_NOW(a_mant_norm, clk, rst_n, state_r == S_SQ, m_r[30])
  `BCE_ASSERT_NEXT(a_sq_done, clk, rst_n, state_r == S_SQ && cnt_r == 4'd15, state_r == S_LN)
  `BCE_ASSERT_NEXT(a_sum_clear, clk, rst_n, state_r == S_OUT && !out_valid_r, acc_r == '0)
endmodule
